### hdl/tfve_pkg.sv
package tfve_pkg;

    localparam int ModeW    = 4;
    localparam int ValueW   = 64;
    localparam int ByteW    = 8;
    localparam int GroupW   = 7;
    localparam int CntW     = 4;
    localparam int InTdataW = 72;

    localparam logic [ModeW-1:0] MODE_BYTE   = 4'd0;
    localparam logic [ModeW-1:0] MODE_BOOL   = 4'd1;
    localparam logic [ModeW-1:0] MODE_S16    = 4'd2;
    localparam logic [ModeW-1:0] MODE_U16    = 4'd3;
    localparam logic [ModeW-1:0] MODE_S32    = 4'd4;
    localparam logic [ModeW-1:0] MODE_U32    = 4'd5;
    localparam logic [ModeW-1:0] MODE_S64    = 4'd6;
    localparam logic [ModeW-1:0] MODE_U64    = 4'd7;
    localparam logic [ModeW-1:0] MODE_ENUM16 = 4'd8;
    localparam logic [ModeW-1:0] MODE_ENUM32 = 4'd9;

    // What the serialiser loads for one field
    typedef struct packed {
        logic              valid;   // type code defined, at least one byte follows
        logic              varint;  // shift right by groups, else left by bytes
        logic [CntW-1:0]   cnt;     // byte count for the fixed-width form
        logic [ValueW-1:0] data;
    } load_t;

endpackage

### hdl/tfve_prep.sv
module tfve_prep
(
    input  logic [tfve_pkg::ModeW-1:0]  mode,
    input  logic [tfve_pkg::ValueW-1:0] value,
    input  logic                        varint_enable,
    output tfve_pkg::load_t             load
);

    logic [15:0] zz16;
    logic [31:0] zz32;
    logic [63:0] zz64;

    // Zigzag at the type's width: shift up, fold the sign over every bit
    assign zz16 = {value[14:0], 1'b0} ^ {16{value[15]}};
    assign zz32 = {value[30:0], 1'b0} ^ {32{value[31]}};
    assign zz64 = {value[62:0], 1'b0} ^ {64{value[63]}};

    always_comb
    begin
        load.valid  = 1'b1;
        load.varint = 1'b0;
        load.cnt    = tfve_pkg::CntW'(1);
        load.data   = '0;
        unique case (mode)
            tfve_pkg::MODE_BYTE:
            begin
                load.data = {value[7:0], 56'b0};
            end
            tfve_pkg::MODE_BOOL:
            begin
                load.data = {7'b0, |value, 56'b0};
            end
            tfve_pkg::MODE_S16, tfve_pkg::MODE_U16:
            begin
                load.varint = varint_enable;
                load.cnt    = tfve_pkg::CntW'(2);
                if (varint_enable)
                    load.data = {48'b0, (mode == tfve_pkg::MODE_S16) ? zz16 : value[15:0]};
                else
                    load.data = {value[15:0], 48'b0};
            end
            tfve_pkg::MODE_S32, tfve_pkg::MODE_U32:
            begin
                load.varint = varint_enable;
                load.cnt    = tfve_pkg::CntW'(4);
                if (varint_enable)
                    load.data = {32'b0, (mode == tfve_pkg::MODE_S32) ? zz32 : value[31:0]};
                else
                    load.data = {value[31:0], 32'b0};
            end
            tfve_pkg::MODE_S64, tfve_pkg::MODE_U64:
            begin
                load.varint = varint_enable;
                load.cnt    = tfve_pkg::CntW'(8);
                if (varint_enable && mode == tfve_pkg::MODE_S64)
                    load.data = zz64;
                else
                    load.data = value;
            end
            tfve_pkg::MODE_ENUM16:
            begin
                load.cnt  = tfve_pkg::CntW'(2);
                load.data = {value[15:0], 48'b0};
            end
            tfve_pkg::MODE_ENUM32:
            begin
                load.cnt  = tfve_pkg::CntW'(4);
                load.data = {value[31:0], 32'b0};
            end
            default:
            begin
                // undefined type code: no bytes
                load.valid = 1'b0;
            end
        endcase
    end

endmodule

### hdl/typed_field_varint_encoder_core.sv
// Typed scalar field encoder.
// Input stream (s_*): one item per field, tdata = {zero pad, value[63:0], mode[3:0]}.
// Output stream (m_*): one item per serialised byte, tdata = byte, tlast on the
// final byte of the field. Config channel (cfg_*): writes varint_enable, always
// ready; write it only while the block is idle.
// A taken field is loaded into the shifter; each byte then passes through the
// output register, one byte per cycle while the receiver takes them. The input
// is held off while a field of N bytes shifts out; N is 1 for byte and bool, 2
// or 4 for enums, 2/4/8 for fixed-width integers and up to 3/5/10 for varints.
// The single 64-bit shift register moves one byte or one 7-bit group per cycle
// unless the output stalls. Undefined type codes are taken and produce no bytes.
// Reset (rst_n low, asynchronous) clears varint_enable, the shifter and the
// output valid flag. When the receiver stalls, the output byte holds and the
// shifter waits; a new field is taken as soon as the previous one has been
// fully shifted out, even if its last byte is still waiting.
module typed_field_varint_encoder_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tfve_pkg::InTdataW-1:0]  s_tdata,   // [3:0] mode, [67:4] value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tfve_pkg::ByteW-1:0]     m_tdata,   // [7:0] out_byte
    output logic                           m_tlast,   // last
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data   // varint_enable
);

    tfve_pkg::load_t                 load;
    logic                            varint_enable_reg;
    logic                            busy_reg;
    logic                            varint_reg;
    logic [tfve_pkg::CntW-1:0]       cnt_reg;
    logic [tfve_pkg::ValueW-1:0]     sh_reg;
    logic                            out_valid_reg;
    logic [tfve_pkg::ByteW-1:0]      out_byte_reg;
    logic                            out_last_reg;
    logic                            accept;
    logic                            emit;
    logic                            more;
    logic                            emit_last;
    logic [tfve_pkg::ByteW-1:0]      emit_byte;

    tfve_prep u_prep
    (
        .mode          (s_tdata[tfve_pkg::ModeW-1:0]),
        .value         (s_tdata[tfve_pkg::ModeW +: tfve_pkg::ValueW]),
        .varint_enable (varint_enable_reg),
        .load          (load)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign emit      = busy_reg && (!out_valid_reg || m_tready);

    // Varint continues while any bit remains above the current group
    assign more      = |sh_reg[tfve_pkg::ValueW-1:tfve_pkg::GroupW];
    assign emit_last = varint_reg ? !more : (cnt_reg == tfve_pkg::CntW'(1));
    assign emit_byte = varint_reg ? {more, sh_reg[tfve_pkg::GroupW-1:0]}
                                  : sh_reg[tfve_pkg::ValueW-1 -: tfve_pkg::ByteW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            varint_enable_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            varint_enable_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            varint_reg <= 1'b0;
            cnt_reg    <= '0;
            sh_reg     <= '0;
        end
        else if (accept)
        begin
            busy_reg   <= load.valid;
            varint_reg <= load.varint;
            cnt_reg    <= load.cnt;
            sh_reg     <= load.data;
        end
        else if (emit)
        begin
            // advance one group or one byte
            busy_reg <= !emit_last;
            cnt_reg  <= cnt_reg - tfve_pkg::CntW'(1);
            if (varint_reg)
                sh_reg <= sh_reg >> tfve_pkg::GroupW;
            else
                sh_reg <= sh_reg << tfve_pkg::ByteW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && load.valid |=> busy_reg && !s_tready)
        else $error("defined field taken but shifter not busy");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && emit_last |=> !busy_reg && m_tvalid && m_tlast)
        else $error("final byte did not end the field");

    a_fixed_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !varint_reg |-> cnt_reg != '0)
        else $error("fixed-width byte count ran out while busy");
`endif

endmodule
